@@ rtl/mfre_pkg.sv @@
`default_nettype none

package mfre_pkg;

  localparam int MAX_DIM = 128;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = 8;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;

  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(MAX_DIM & ~1);

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_XFORM  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_RELOAD = 2'd3
  } cmd_t;

  localparam logic [2:0] OP_FLIP_V   = 3'd1;
  localparam logic [2:0] OP_MIRROR_H = 3'd2;
  localparam logic [2:0] OP_ROT_CW   = 3'd3;
  localparam logic [2:0] OP_ROT_CCW  = 3'd4;
  localparam logic [2:0] OP_QUAD_CW  = 3'd5;
  localparam logic [2:0] OP_QUAD_CCW = 3'd6;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XFORM,
    ST_COPY
  } state_t;

  function automatic logic [DIM_W-1:0] legal_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] e;
    e = {v[DIM_W-1:1], 1'b0};
    if (e < DIM_MIN) begin
      e = DIM_MIN;
    end else if (e > DIM_LIM) begin
      e = DIM_LIM;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

@@ rtl/matrix_flip_rotate_engine.sv @@
// channel   signals                                      handshake
// item in   cmd op row_index col_index write_value       start & !busy
// result    read_value rows_now cols_now                 done, one cycle
// config    cfg_index cfg_data                           cfg_valid & cfg_ready
//
// write, read and reload items do not hold busy; a read result shows on done
// in the cycle after the item is taken.
// a transform makes one pass through the element memory into the scratch
// memory and one pass copying back, one word per cycle on each memory port.
// synchronous reset; memory contents are not cleared. results cannot be stalled.
`default_nettype none

module matrix_flip_rotate_engine (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   cmd,
  input  wire logic [2:0]                   op,
  input  wire logic [mfre_pkg::IDX_W-1:0]   row_index,
  input  wire logic [mfre_pkg::IDX_W-1:0]   col_index,
  input  wire logic [mfre_pkg::DATA_W-1:0]  write_value,
  output logic                              done,
  output logic [mfre_pkg::DATA_W-1:0]       read_value,
  output logic [mfre_pkg::DIM_W-1:0]        rows_now,
  output logic [mfre_pkg::DIM_W-1:0]        cols_now,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [mfre_pkg::DIM_W-1:0]   cfg_data
);

  localparam int IW = mfre_pkg::IDX_W;
  localparam int DW = mfre_pkg::DIM_W;
  localparam int AW = mfre_pkg::ADDR_W;
  localparam int VW = mfre_pkg::DATA_W;

  logic [VW-1:0] elem_mem    [mfre_pkg::DEPTH];
  logic [VW-1:0] scratch_mem [mfre_pkg::DEPTH];

  mfre_pkg::state_t state, state_next;

  logic [DW-1:0] initial_rows, initial_cols;
  logic [DW-1:0] row_count, col_count;
  logic [DW-1:0] new_rows, new_cols;
  logic [2:0]    op_q;
  logic [IW-1:0] cnt_r, cnt_c, cnt_r_next, cnt_c_next;
  logic          xf_wen, cp_wen, xf_wen_next, cp_wen_next;
  logic [AW-1:0] xf_waddr, cp_waddr;
  logic          rd_pend, rd_inr;

  logic [VW-1:0] e_rdata, s_rdata, e_wdata;
  logic [AW-1:0] e_raddr, e_waddr, cnt_addr;
  logic          e_we;

  logic          accept, in_range, op_known, is_rot, last_elem, finish;
  logic [DW-1:0] r8, c8, hr, hc, src_r, src_c;

  assign accept   = start && !busy;
  assign in_range = (DW'(row_index) < row_count) && (DW'(col_index) < col_count);
  assign op_known = (op == mfre_pkg::OP_FLIP_V)  || (op == mfre_pkg::OP_MIRROR_H) ||
                    (op == mfre_pkg::OP_ROT_CW)  || (op == mfre_pkg::OP_ROT_CCW) ||
                    (op == mfre_pkg::OP_QUAD_CW) || (op == mfre_pkg::OP_QUAD_CCW);
  assign is_rot   = (op == mfre_pkg::OP_ROT_CW) || (op == mfre_pkg::OP_ROT_CCW);

  assign busy      = (state != mfre_pkg::ST_IDLE) || cp_wen;
  assign cfg_ready = 1'b1;
  assign done      = rd_pend;
  assign read_value = rd_inr ? e_rdata : '0;
  assign rows_now  = row_count;
  assign cols_now  = col_count;

  assign r8        = DW'(cnt_r);
  assign c8        = DW'(cnt_c);
  assign hr        = row_count >> 1;
  assign hc        = col_count >> 1;
  assign cnt_addr  = {cnt_r, cnt_c};
  assign last_elem = (r8 == new_rows - DW'(1)) && (c8 == new_cols - DW'(1));

  // source element for the current destination, old dimensions still in force
  always_comb begin
    src_r = r8;
    src_c = c8;
    unique case (op_q)
      mfre_pkg::OP_FLIP_V: begin
        src_r = row_count - DW'(1) - r8;
      end
      mfre_pkg::OP_MIRROR_H: begin
        src_c = col_count - DW'(1) - c8;
      end
      mfre_pkg::OP_ROT_CW: begin
        src_r = row_count - DW'(1) - c8;
        src_c = r8;
      end
      mfre_pkg::OP_ROT_CCW: begin
        src_r = c8;
        src_c = col_count - DW'(1) - r8;
      end
      mfre_pkg::OP_QUAD_CW: begin
        priority if (r8 < hr && c8 < hc) begin
          src_r = r8 + hr;
        end else if (r8 < hr) begin
          src_c = c8 - hc;
        end else if (c8 >= hc) begin
          src_r = r8 - hr;
        end else begin
          src_c = c8 + hc;
        end
      end
      mfre_pkg::OP_QUAD_CCW: begin
        priority if (r8 < hr && c8 < hc) begin
          src_c = c8 + hc;
        end else if (r8 < hr) begin
          src_r = r8 + hr;
        end else if (c8 >= hc) begin
          src_c = c8 - hc;
        end else begin
          src_r = r8 - hr;
        end
      end
      default: begin
        src_r = r8;
        src_c = c8;
      end
    endcase
  end

  always_comb begin
    state_next  = state;
    cnt_r_next  = cnt_r;
    cnt_c_next  = cnt_c;
    xf_wen_next = 1'b0;
    cp_wen_next = 1'b0;
    finish      = 1'b0;
    unique case (state)
      mfre_pkg::ST_IDLE: begin
        if (accept && mfre_pkg::cmd_t'(cmd) == mfre_pkg::CMD_XFORM && op_known) begin
          state_next = mfre_pkg::ST_XFORM;
          cnt_r_next = '0;
          cnt_c_next = '0;
        end
      end
      mfre_pkg::ST_XFORM, mfre_pkg::ST_COPY: begin
        if (state == mfre_pkg::ST_XFORM) begin
          xf_wen_next = 1'b1;
        end else begin
          cp_wen_next = 1'b1;
        end
        if (last_elem) begin
          cnt_r_next = '0;
          cnt_c_next = '0;
          if (state == mfre_pkg::ST_XFORM) begin
            state_next = mfre_pkg::ST_COPY;
          end else begin
            state_next = mfre_pkg::ST_IDLE;
            finish     = 1'b1;
          end
        end else if (c8 == new_cols - DW'(1)) begin
          cnt_c_next = '0;
          cnt_r_next = cnt_r + IW'(1);
        end else begin
          cnt_c_next = cnt_c + IW'(1);
        end
      end
      default: begin
        state_next = mfre_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mfre_pkg::ST_IDLE;
      xf_wen       <= 1'b0;
      cp_wen       <= 1'b0;
      rd_pend      <= 1'b0;
      row_count    <= mfre_pkg::DIM_MIN;
      col_count    <= mfre_pkg::DIM_MIN;
      initial_rows <= mfre_pkg::DIM_MIN;
      initial_cols <= mfre_pkg::DIM_MIN;
    end else begin
      state   <= state_next;
      xf_wen  <= xf_wen_next;
      cp_wen  <= cp_wen_next;
      rd_pend <= accept && mfre_pkg::cmd_t'(cmd) == mfre_pkg::CMD_READ;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mfre_pkg::CFG_ROWS) begin
          initial_rows <= cfg_data;
        end else begin
          initial_cols <= cfg_data;
        end
      end
      if (accept && mfre_pkg::cmd_t'(cmd) == mfre_pkg::CMD_RELOAD) begin
        row_count <= mfre_pkg::legal_dim(initial_rows);
        col_count <= mfre_pkg::legal_dim(initial_cols);
      end else if (finish) begin
        row_count <= new_rows;
        col_count <= new_cols;
      end
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_r_next;
    cnt_c    <= cnt_c_next;
    xf_waddr <= cnt_addr;
    cp_waddr <= cnt_addr;
    rd_inr   <= in_range;
    if (state == mfre_pkg::ST_IDLE && accept) begin
      op_q     <= op;
      new_rows <= is_rot ? col_count : row_count;
      new_cols <= is_rot ? row_count : col_count;
    end
  end

  assign e_we    = cp_wen ||
                   (accept && mfre_pkg::cmd_t'(cmd) == mfre_pkg::CMD_WRITE && in_range);
  assign e_waddr = cp_wen ? cp_waddr : {row_index, col_index};
  assign e_wdata = cp_wen ? s_rdata : write_value;
  assign e_raddr = (state == mfre_pkg::ST_XFORM) ? {src_r[IW-1:0], src_c[IW-1:0]}
                                                 : {row_index, col_index};

  always_ff @(posedge clk) begin
    if (e_we) begin
      elem_mem[e_waddr] <= e_wdata;
    end
    e_rdata <= elem_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (xf_wen) begin
      scratch_mem[xf_waddr] <= e_rdata;
    end
    s_rdata <= scratch_mem[cnt_addr];
  end

endmodule

`default_nettype wire

@@ rtl/mfre_checker.sv @@
`default_nettype none

module mfre_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic [1:0]                   cmd,
  input wire logic [2:0]                   op,
  input wire logic                         done,
  input wire logic [mfre_pkg::DIM_W-1:0]   rows_now,
  input wire logic [mfre_pkg::DIM_W-1:0]   cols_now
);

  // a result only follows a read item taken in the cycle before
  a_done_after_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && cmd == mfre_pkg::CMD_READ))
    else $error("result without a read item");

  // reported dimensions stay even and within range
  a_dims_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (rows_now[0] == 1'b0 && cols_now[0] == 1'b0 &&
              rows_now >= mfre_pkg::DIM_MIN && rows_now <= mfre_pkg::DIM_LIM &&
              cols_now >= mfre_pkg::DIM_MIN && cols_now <= mfre_pkg::DIM_LIM))
    else $error("illegal dimensions");

  a_rotate_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == mfre_pkg::CMD_XFORM && op == mfre_pkg::OP_ROT_CW) |=> busy)
    else $error("rotate item did not start a transform");

  a_write_single: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == mfre_pkg::CMD_WRITE) |=> !busy)
    else $error("write item held the block");

  a_no_done_at_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> !done)
    else $error("result at end of transform");

endmodule

bind matrix_flip_rotate_engine mfre_checker u_mfre_checker (.*);

`default_nettype wire

@@ verif/matrix_flip_rotate_engine_tb.sv @@
`default_nettype none

module matrix_flip_rotate_engine_tb;

  // op codes 0 and 7 leave the matrix alone
  localparam logic [2:0] OP_NOP_ZERO  = 3'd0;
  localparam logic [2:0] OP_NOP_SEVEN = 3'd7;
  localparam int         DIM_TOP      = mfre_pkg::MAX_DIM - (mfre_pkg::MAX_DIM % 2);

  typedef struct packed {
    logic [mfre_pkg::DATA_W-1:0] value;
    logic [mfre_pkg::DIM_W-1:0]  rows;
    logic [mfre_pkg::DIM_W-1:0]  cols;
  } read_reply_t;

  logic                         clk         = 1'b0;
  logic                         rst         = 1'b1;
  logic                         start       = 1'b0;
  mfre_pkg::cmd_t               cmd         = mfre_pkg::CMD_WRITE;
  logic [2:0]                   op          = OP_NOP_ZERO;
  logic [mfre_pkg::IDX_W-1:0]   row_index   = '0;
  logic [mfre_pkg::IDX_W-1:0]   col_index   = '0;
  logic [mfre_pkg::DATA_W-1:0]  write_value = '0;
  logic                         cfg_valid   = 1'b0;
  logic                         cfg_index   = mfre_pkg::CFG_ROWS;
  logic [mfre_pkg::DIM_W-1:0]   cfg_data    = '0;
  wire logic                    busy;
  wire logic                    done;
  wire logic                    cfg_ready;
  wire logic [mfre_pkg::DATA_W-1:0] read_value;
  wire logic [mfre_pkg::DIM_W-1:0]  rows_now;
  wire logic [mfre_pkg::DIM_W-1:0]  cols_now;

  matrix_flip_rotate_engine u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .op          (op),
    .row_index   (row_index),
    .col_index   (col_index),
    .write_value (write_value),
    .done        (done),
    .read_value  (read_value),
    .rows_now    (rows_now),
    .cols_now    (cols_now),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // matrix shadow: words plus a flag for every word that holds written data
  logic [mfre_pkg::DATA_W-1:0] grid_word     [mfre_pkg::DEPTH];
  bit                          grid_known    [mfre_pkg::DEPTH];
  logic [mfre_pkg::DATA_W-1:0] scratch_word  [mfre_pkg::DEPTH];
  bit                          scratch_known [mfre_pkg::DEPTH];
  int                          rows_cur = 2;
  int                          cols_cur = 2;
  logic [mfre_pkg::DIM_W-1:0]  reload_rows = mfre_pkg::DIM_W'(2);
  logic [mfre_pkg::DIM_W-1:0]  reload_cols = mfre_pkg::DIM_W'(2);

  read_reply_t pending_reads[$];
  int          mismatches = 0;
  int          idle_pct   = 0;

  function automatic int word_addr(input int r, input int c);
    return r * mfre_pkg::MAX_DIM + c;
  endfunction

  function automatic int clamp_dim(input logic [mfre_pkg::DIM_W-1:0] raw);
    int d;
    d = int'({raw[mfre_pkg::DIM_W-1:1], 1'b0});
    if (d < 2) d = 2;
    if (d > DIM_TOP) d = DIM_TOP;
    return d;
  endfunction

  function automatic void stage(input int dst, input int src);
    scratch_word[dst]  = grid_word[src];
    scratch_known[dst] = grid_known[src];
  endfunction

  function automatic void move_quarter(input int sr, input int sc, input int dr,
                                       input int dc, input int hr, input int hc);
    int r, c;
    for (r = 0; r < hr; r++)
      for (c = 0; c < hc; c++)
        stage(word_addr(dr + r, dc + c), word_addr(sr + r, sc + c));
  endfunction

  function automatic void apply_transform(input logic [2:0] code);
    int rows, cols, hr, hc, r, c, a;
    rows = rows_cur;
    cols = cols_cur;
    hr = rows / 2;
    hc = cols / 2;
    unique case (code)
      mfre_pkg::OP_FLIP_V: begin
        for (r = 0; r < rows; r++)
          for (c = 0; c < cols; c++)
            stage(word_addr(rows - 1 - r, c), word_addr(r, c));
      end
      mfre_pkg::OP_MIRROR_H: begin
        for (r = 0; r < rows; r++)
          for (c = 0; c < cols; c++)
            stage(word_addr(r, cols - 1 - c), word_addr(r, c));
      end
      mfre_pkg::OP_ROT_CW: begin
        rows_cur = cols;
        cols_cur = rows;
        for (r = 0; r < cols; r++)
          for (c = 0; c < rows; c++)
            stage(word_addr(r, c), word_addr(rows - 1 - c, r));
      end
      mfre_pkg::OP_ROT_CCW: begin
        rows_cur = cols;
        cols_cur = rows;
        for (r = 0; r < cols; r++)
          for (c = 0; c < rows; c++)
            stage(word_addr(r, c), word_addr(c, cols - 1 - r));
      end
      mfre_pkg::OP_QUAD_CW: begin
        move_quarter(0, 0, 0, hc, hr, hc);
        move_quarter(0, hc, hr, hc, hr, hc);
        move_quarter(hr, hc, hr, 0, hr, hc);
        move_quarter(hr, 0, 0, 0, hr, hc);
      end
      mfre_pkg::OP_QUAD_CCW: begin
        move_quarter(0, 0, hr, 0, hr, hc);
        move_quarter(0, hc, 0, 0, hr, hc);
        move_quarter(hr, hc, 0, hc, hr, hc);
        move_quarter(hr, 0, hr, hc, hr, hc);
      end
      default: return;
    endcase
    for (r = 0; r < rows_cur; r++)
      for (c = 0; c < cols_cur; c++) begin
        a = word_addr(r, c);
        grid_word[a]  = scratch_word[a];
        grid_known[a] = scratch_known[a];
      end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_reads
    read_reply_t want;
    if (!rst && done) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected read result %h rows %0d cols %0d",
                                  read_value, rows_now, cols_now));
      end else begin
        want = pending_reads.pop_front();
        if (read_value !== want.value || rows_now !== want.rows ||
            cols_now !== want.cols) begin
          report_mismatch($sformatf("read got %h/%0d/%0d want %h/%0d/%0d",
                                    read_value, rows_now, cols_now,
                                    want.value, want.rows, want.cols));
        end
      end
    end
  end

  // to be called right after the clock rises; returns when the item has been taken, after any idle gap
  task automatic send_item(input mfre_pkg::cmd_t kind, input logic [2:0] code,
                           input int r, input int c,
                           input logic [mfre_pkg::DATA_W-1:0] v);
    int  a, n;
    bit  in_range;
    in_range = (r < rows_cur) && (c < cols_cur);
    a = word_addr(r, c);
    // never read an in-range word that was never written: write it instead
    if (kind == mfre_pkg::CMD_READ && in_range && !grid_known[a]) begin
      kind = mfre_pkg::CMD_WRITE;
    end
    start       <= 1'b1;
    cmd         <= kind;
    op          <= code;
    row_index   <= mfre_pkg::IDX_W'(r);
    col_index   <= mfre_pkg::IDX_W'(c);
    write_value <= v;
    do @(posedge clk); while (busy);
    unique case (kind)
      mfre_pkg::CMD_WRITE: begin
        if (in_range) begin
          grid_word[a]  = v;
          grid_known[a] = 1'b1;
        end
      end
      mfre_pkg::CMD_XFORM: apply_transform(code);
      mfre_pkg::CMD_READ: begin
        pending_reads.push_back('{value: in_range ? grid_word[a] : '0,
                                  rows: mfre_pkg::DIM_W'(rows_cur),
                                  cols: mfre_pkg::DIM_W'(cols_cur)});
      end
      default: begin
        rows_cur = clamp_dim(reload_rows);
        cols_cur = clamp_dim(reload_cols);
      end
    endcase
    n = 0;
    while (n < 40 && $urandom_range(0, 99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending, let every read come back and any transform finish
  task automatic settle();
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_dims(input logic [mfre_pkg::DIM_W-1:0] rows_raw,
                              input logic [mfre_pkg::DIM_W-1:0] cols_raw);
    cfg_valid <= 1'b1;
    cfg_index <= mfre_pkg::CFG_ROWS;
    cfg_data  <= rows_raw;
    do @(posedge clk); while (!cfg_ready);
    reload_rows = rows_raw;
    cfg_index <= mfre_pkg::CFG_COLS;
    cfg_data  <= cols_raw;
    do @(posedge clk); while (!cfg_ready);
    reload_cols = cols_raw;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_and_bounds();
    idle_pct = 0;
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 2, 0, '0);
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 0, 0, 32'h0000_0000);
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 0, 1, 32'hFFFF_FFFF);
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 1, 0, 32'hAAAA_AAAA);
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 1, 1, 32'h5555_5555);
    // writes outside the current dimensions are dropped
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 1, 2, 32'h1234_5678);
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 127, 127, 32'h8765_4321);
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 1, 1, '0);
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 0, 1, '0);
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 127, 127, '0);
    send_item(mfre_pkg::CMD_RELOAD, OP_NOP_ZERO, 0, 0, '0);
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 1, 0, '0);
    settle();
  endtask

  task automatic test_every_op();
    logic [2:0] codes[8];
    int i;
    codes = '{OP_NOP_ZERO, mfre_pkg::OP_FLIP_V, mfre_pkg::OP_MIRROR_H,
              mfre_pkg::OP_ROT_CW, mfre_pkg::OP_ROT_CCW, mfre_pkg::OP_QUAD_CW,
              mfre_pkg::OP_QUAD_CCW, OP_NOP_SEVEN};
    idle_pct = 0;
    // odd register values lose their low bit: 2 rows by 4 columns
    program_dims(mfre_pkg::DIM_W'(3), mfre_pkg::DIM_W'(5));
    send_item(mfre_pkg::CMD_RELOAD, OP_NOP_ZERO, 0, 0, '0);
    for (i = 0; i < 4; i++)
      send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, i / 2, 2 + i % 2, $urandom());
    for (i = 0; i < 8; i++) begin
      send_item(mfre_pkg::CMD_XFORM, codes[i], 0, 0, '0);
      send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 0, 1, '0);
    end
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 3, 1, '0);
    settle();
  endtask

  task automatic test_dim_extremes();
    idle_pct = 38;
    // zero clamps up to two, all ones clamps down to the largest even size
    program_dims(mfre_pkg::DIM_W'(0), mfre_pkg::DIM_W'(255));
    send_item(mfre_pkg::CMD_RELOAD, OP_NOP_SEVEN, 127, 127, '1);
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 1, 127, $urandom());
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 1, 127, '0);
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 2, 0, '0);
    settle();
    program_dims(mfre_pkg::DIM_W'(129), mfre_pkg::DIM_W'(1));
    send_item(mfre_pkg::CMD_RELOAD, OP_NOP_ZERO, 0, 0, '0);
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 127, 1, $urandom());
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 127, 1, '0);
    settle();
    program_dims(mfre_pkg::DIM_W'(255), mfre_pkg::DIM_W'(128));
    send_item(mfre_pkg::CMD_RELOAD, OP_NOP_ZERO, 0, 0, '0);
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 0, 0, $urandom());
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 0, 127, $urandom());
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 127, 0, $urandom());
    send_item(mfre_pkg::CMD_WRITE, OP_NOP_ZERO, 127, 127, $urandom());
    send_item(mfre_pkg::CMD_XFORM, mfre_pkg::OP_ROT_CW, 0, 0, '0);
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 0, 127, '0);
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 127, 0, '0);
    send_item(mfre_pkg::CMD_XFORM, mfre_pkg::OP_QUAD_CCW, 0, 0, '0);
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 64, 127, '0);
    send_item(mfre_pkg::CMD_READ, OP_NOP_ZERO, 63, 0, '0);
    settle();
  endtask

  task automatic random_run(input int count);
    int             i, pick, r, c;
    mfre_pkg::cmd_t kind;
    logic [2:0]     code;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      code = 3'($urandom_range(0, 7));
      r = $urandom_range(0, 127);
      c = $urandom_range(0, 127);
      if (pick < 62) begin
        kind = (pick < 35) ? mfre_pkg::CMD_READ : mfre_pkg::CMD_WRITE;
        // mostly inside the matrix, now and then anywhere
        if ($urandom_range(0, 5) != 0) begin
          r = $urandom_range(0, rows_cur - 1);
          c = $urandom_range(0, cols_cur - 1);
        end
      end else if (pick < 87) begin
        kind = mfre_pkg::CMD_XFORM;
      end else if (pick < 92) begin
        kind = mfre_pkg::CMD_RELOAD;
      end else begin
        kind = mfre_pkg::cmd_t'($urandom_range(0, 3));
      end
      send_item(kind, code, r, c, $urandom());
    end
  endtask

  task automatic test_random_phases();
    int levels[3];
    int p, s;
    logic [mfre_pkg::DIM_W-1:0] big, tiny;
    levels = '{0, 78, 38};
    for (p = 0; p < 3; p++) begin
      idle_pct = levels[p];
      for (s = 0; s < 3; s++) begin
        tiny = mfre_pkg::DIM_W'($urandom_range(0, 9));
        if ($urandom_range(0, 4) == 0) begin
          // one side of any size, the other short, keeps transforms quick
          big = mfre_pkg::DIM_W'($urandom_range(0, 255));
          if ($urandom_range(0, 1) != 0) program_dims(big, tiny);
          else program_dims(tiny, big);
        end else begin
          program_dims(tiny, mfre_pkg::DIM_W'($urandom_range(0, 9)));
        end
        send_item(mfre_pkg::CMD_RELOAD, OP_NOP_ZERO, 0, 0, '0);
        random_run(5);
        settle();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_and_bounds();
    test_every_op();
    test_dim_extremes();
    test_random_phases();
    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
